### src/bpa_pkg.sv
// Shared types and constants for the bitmap page allocator.
// Used by the controller, the datapath and the top level.
package bpa_pkg;

  localparam int unsigned NumPagesDefault = 65536;
  localparam int unsigned WordBitsDefault = 32;

  typedef enum logic [2:0] {
    ACT_ALLOC_ONE = 3'd0,
    ACT_ALLOC_RUN = 3'd1,
    ACT_FREE_RUN  = 3'd2,
    ACT_RESERVE   = 3'd3,
    ACT_TEST      = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_TEST,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clr_step;
    logic scan_step;
    logic mark_step;
    logic test_step;
    logic fail;
  } bpa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic scan_hit;
    logic scan_end;
    logic mark_end;
    logic no_scan;
  } bpa_sts_t;

endpackage

### src/bpa_datapath.sv
// Datapath of the bitmap page allocator: used map memory, used count and
// page counters for clearing, scanning, marking and testing. Uses bpa_pkg.
module bpa_datapath import bpa_pkg::*; #(
  parameter int unsigned NumPages = NumPagesDefault,
  parameter int unsigned WordBits = WordBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bpa_cmd_t    cmd_i,
  output bpa_sts_t    sts_o,
  input  logic [2:0]  action_i,
  input  logic [15:0] page_index_i,
  input  logic [16:0] page_count_i,
  output logic        ok_o,
  output logic [15:0] result_page_o,
  output logic        page_bit_o,
  output logic [16:0] pages_used_o
);

  localparam int unsigned MapWords = (NumPages + WordBits - 1) / WordBits;
  localparam int unsigned PW = $clog2(NumPages + 1);
  localparam int unsigned AW = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int unsigned BW = (WordBits > 1) ? $clog2(WordBits) : 1;
  localparam int unsigned CW = (PW > 17) ? PW : 17;
  localparam logic [PW-1:0] NumPagesP = PW'(NumPages);

  logic [WordBits-1:0] mem [MapWords];
  logic [WordBits-1:0] rd_word;
  logic [WordBits-1:0] rd_raw_q;
  logic [WordBits-1:0] fwd_q;
  logic                fwd_sel_q;
  logic [WordBits-1:0] wr_word;
  logic                wr_en;

  logic [PW-1:0] cnt_q, cnt_d;       // current page
  logic [PW-1:0] end_q, end_d;       // one past the last page to mark
  logic [PW-1:0] start_q, start_d;   // run start during scan
  logic [CW-1:0] len_q, len_d;       // current free run length
  logic [CW-1:0] need_q, need_d;
  logic [PW-1:0] used_q, used_d;
  logic          setv_q, setv_d;
  logic          ok_q, ok_d, bit_q, bit_d;
  logic [PW-1:0] page_q, page_d;
  logic [CW-1:0] act_cnt;
  logic [CW:0]   end_wide;

  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [BW-1:0] boff;
  logic          cur_bit;
  logic          in_range;

  assign waddr    = AW'(cnt_q / WordBits);
  assign raddr    = AW'(cnt_d / WordBits);
  assign boff     = BW'(cnt_q % WordBits);
  assign in_range = cnt_q < NumPagesP;

  // The word for the next page is read ahead from cnt_d, so the registered
  // read data always belongs to the page counter. A write to the word being
  // read in the same cycle is forwarded.
  assign wr_en   = cmd_i.clr_step || (cmd_i.mark_step && in_range);
  assign wr_word = cmd_i.clr_step ? '1
                 : (setv_q ? (rd_word | (WordBits'(1) << boff))
                           : (rd_word & ~(WordBits'(1) << boff)));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= wr_word;
    end
    rd_raw_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    fwd_q     <= wr_word;
    fwd_sel_q <= wr_en && (raddr == waddr);
  end

  assign rd_word = fwd_sel_q ? fwd_q : rd_raw_q;
  assign cur_bit = rd_word[boff];

  always_comb begin
    act_cnt = CW'(page_count_i);
    if (action_i == ACT_ALLOC_ONE || page_count_i == '0) begin
      act_cnt = CW'(1);
    end
    end_wide = (CW + 1)'(page_index_i) + (CW + 1)'(page_count_i);
  end

  always_comb begin
    cnt_d   = cnt_q;
    end_d   = end_q;
    start_d = start_q;
    len_d   = len_q;
    need_d  = need_q;
    used_d  = used_q;
    setv_d  = setv_q;
    ok_d    = ok_q;
    bit_d   = bit_q;
    page_d  = page_q;
    if (cmd_i.clr_step) begin
      cnt_d = cnt_q + PW'(WordBits);
    end
    if (cmd_i.load) begin
      ok_d   = 1'b1;
      bit_d  = 1'b0;
      page_d = '0;
      len_d  = '0;
      need_d = act_cnt;
      if (action_i == ACT_ALLOC_ONE || action_i == ACT_ALLOC_RUN) begin
        cnt_d  = '0;
        setv_d = 1'b1;
      end else begin
        cnt_d  = PW'(page_index_i);
        setv_d = (action_i == ACT_RESERVE);
        if (end_wide > (CW + 1)'(NumPages)) begin
          end_d = NumPagesP;
        end else begin
          end_d = PW'(end_wide);
        end
      end
    end
    if (cmd_i.scan_step) begin
      if (cur_bit) begin
        len_d = '0;
      end else begin
        if (len_q == '0) begin
          start_d = cnt_q;
        end
        len_d = len_q + CW'(1);
      end
      if (sts_o.scan_hit) begin
        // Found: mark from the run start.
        page_d = (len_q == '0) ? cnt_q : start_q;
        cnt_d  = page_d;
        end_d  = page_d + PW'(need_q);
      end else begin
        cnt_d = cnt_q + PW'(1);
      end
    end
    if (cmd_i.mark_step) begin
      if (in_range) begin
        if (setv_q && !cur_bit) begin
          used_d = used_q + PW'(1);
        end else if (!setv_q && cur_bit) begin
          used_d = used_q - PW'(1);
        end
      end
      cnt_d = cnt_q + PW'(1);
    end
    if (cmd_i.test_step) begin
      bit_d = in_range ? cur_bit : 1'b1;
    end
    if (cmd_i.fail) begin
      ok_d   = 1'b0;
      page_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      used_q <= NumPagesP;
    end else begin
      cnt_q  <= cnt_d;
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q   <= end_d;
    start_q <= start_d;
    len_q   <= len_d;
    need_q  <= need_d;
    setv_q  <= setv_d;
    ok_q    <= ok_d;
    bit_q   <= bit_d;
    page_q  <= page_d;
  end

  assign sts_o.clr_last = (waddr == AW'(MapWords - 1));
  assign sts_o.scan_hit = !cur_bit && ((len_q + CW'(1)) >= need_q);
  assign sts_o.scan_end = (cnt_q == NumPagesP - PW'(1));
  assign sts_o.mark_end = (cnt_q >= end_q);
  assign sts_o.no_scan  = (need_q > CW'(NumPages));

  assign ok_o          = ok_q;
  assign result_page_o = 16'(page_q);
  assign page_bit_o    = bit_q;
  assign pages_used_o  = 17'(used_q);

endmodule

### src/bpa_ctrl.sv
// Controller state machine of the bitmap page allocator.
// Sequences the datapath through bpa_pkg command and status structs.
module bpa_ctrl import bpa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] action_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output bpa_cmd_t   cmd_o,
  input  bpa_sts_t   sts_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (action_i)
            ACT_ALLOC_ONE, ACT_ALLOC_RUN: state_d = ST_SCAN;
            ACT_FREE_RUN, ACT_RESERVE:    state_d = ST_MARK;
            ACT_TEST:                     state_d = ST_TEST;
            default:                      state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (sts_i.no_scan) begin
          cmd_o.fail = 1'b1;
          state_d    = ST_DONE;
        end else begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.scan_hit) begin
            state_d = ST_MARK;
          end else if (sts_i.scan_end) begin
            cmd_o.fail = 1'b1;
            state_d    = ST_DONE;
          end
        end
      end
      ST_MARK: begin
        if (sts_i.mark_end) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.mark_step = 1'b1;
        end
      end
      ST_TEST: begin
        cmd_o.test_step = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### src/bitmap_page_allocator.sv
// Bitmap page allocator: one used bit per page, first-fit run search.
// Input channel: in_valid_i/in_stall_o with action_i, page_index_i and
// page_count_i. Output channel: out_valid_o/out_stall_i with ok_o,
// result_page_o, page_bit_o and pages_used_o. A transaction moves when
// valid is high and stall is low.
// One action is handled at a time. An allocation scans the map one page
// per cycle from page 0 until a run fits or the map ends, then marks the
// run one page per cycle until a final step sees the run end. Free and
// reserve walk the clipped run the same way; a test reads one page bit.
// The result is offered in the next cycle, and the next input is taken
// in the cycle after the result. After reset a clearing pass writes
// every map word to all used, one word per cycle, with in_stall_o high.
// While the receiver stalls the result holds and no new input is taken.
// Depends on bpa_pkg, bpa_ctrl and bpa_datapath.
module bitmap_page_allocator import bpa_pkg::*; #(
  parameter int unsigned NumPages = NumPagesDefault,
  parameter int unsigned WordBits = WordBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [15:0] page_index_i,
  input  logic [16:0] page_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic [15:0] result_page_o,
  output logic        page_bit_o,
  output logic [16:0] pages_used_o
);

  bpa_cmd_t cmd;
  bpa_sts_t sts;

  bpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bpa_datapath #(
    .NumPages (NumPages),
    .WordBits (WordBits)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (action_i),
    .page_index_i  (page_index_i),
    .page_count_i  (page_count_i),
    .ok_o          (ok_o),
    .result_page_o (result_page_o),
    .page_bit_o    (page_bit_o),
    .pages_used_o  (pages_used_o)
  );

endmodule

### src/bpa_checker.sv
// Port-level checks for the bitmap page allocator.
// Bound to bitmap_page_allocator; depends on its ports only.
module bpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        ok_o,
  input logic [15:0] result_page_o,
  input logic [16:0] pages_used_o
);

  // One action in flight: no input is taken while a result waits.
  a_no_take_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken with result pending");

  // A failed allocation reports page zero.
  a_fail_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (result_page_o == 16'd0))
    else $error("failed allocation with nonzero page");

  // The used count only moves while an action is being worked on.
  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_stall_o && !in_valid_i) |=> $stable(pages_used_o))
    else $error("used count changed while idle");

  // A stalled result stays valid and its used count holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(pages_used_o)))
    else $error("stalled result changed");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .ok_o          (ok_o),
  .result_page_o (result_page_o),
  .pages_used_o  (pages_used_o)
);
